// File: rtl/lc3_pkg.sv
// ----------------------------------------------------------------------------
// LC-3 executor package
// Shared types, widths and codes for the LC-3 instruction executor.
// ----------------------------------------------------------------------------
package lc3_pkg;

	localparam int ADDR_BITS = 16;
	localparam int MEM_WORDS = 1 << ADDR_BITS;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_RESTART = 2'd1,
		OP_EXEC    = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_STOP = 2'd1;
	localparam logic [1:0] ST_RSVD = 2'd2;

	localparam logic [7:0] TRAP_GETC = 8'h20;
	localparam logic [7:0] TRAP_OUT  = 8'h21;
	localparam logic [7:0] TRAP_HALT = 8'h25;

	localparam logic [15:0] IMM_BIT  = 16'h0020;
	localparam logic [15:0] JSR_BIT  = 16'h0800;
	localparam logic [15:0] DR_MASK  = 16'h0E00;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] mem_address;
		logic [15:0] mem_data;
		logic [7:0]  char_in;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pc_value;
		logic [15:0] instr_word;
		logic        is_running;
		logic [1:0]  status;
		logic        reg_write_valid;
		logic [2:0]  reg_write_index;
		logic [15:0] reg_write_value;
		logic [2:0]  cond_codes;
		logic        char_out_valid;
		logic [7:0]  char_out;
	} out_item_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		op_t         op;
		logic [15:0] mem_address;
		logic [15:0] mem_data;
		logic [7:0]  char_in;
	} cmd_t;

	function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
		logic [15:0] m;
		logic [15:0] s;
		m = 16'((32'd1 << bits) - 1);
		s = 16'(32'd1 << (bits - 1));
		return ((v & m) ^ s) - s;
	endfunction

	function automatic logic [2:0] flags_of(input logic [15:0] v);
		if (v[15]) return 3'b100;
		if (v == 16'd0) return 3'b010;
		return 3'b001;
	endfunction

endpackage

// File: rtl/lc3_front.sv
// ----------------------------------------------------------------------------
// LC-3 front end
// Accepts input transactions and queues them as commands for the back end.
// ----------------------------------------------------------------------------
module lc3_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lc3_pkg::in_item_t in_data,
	output logic             cmd_valid,
	input  logic             cmd_take,
	output lc3_pkg::cmd_t    cmd
);
	import lc3_pkg::*;

	cmd_t        q_mem_q [QDEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;
	cmd_t        c;

	assign in_stall  = (cnt_q == 2'(QDEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_mem_q[rp_q];

	always_comb begin
		c.op          = op_t'(in_data.operation);
		c.mem_address = in_data.mem_address;
		c.mem_data    = in_data.mem_data;
		c.char_in     = in_data.char_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= c;
	end

endmodule

// File: rtl/lc3_back.sv
// ----------------------------------------------------------------------------
// LC-3 back end
// Sequencer that executes commands on the register file and word memory.
// ----------------------------------------------------------------------------
module lc3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [15:0]       start_address,
	input  logic              cmd_valid,
	output logic              cmd_take,
	input  lc3_pkg::cmd_t     cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output lc3_pkg::out_item_t out_data
);
	import lc3_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_FETCH, S_DECODE, S_IND, S_FINISH
	} state_t;

	state_t      state_q;
	logic [15:0] mem_q [MEM_WORDS];
	logic [15:0] rf_q [8];
	logic [15:0] pc_q, ir_q, rd_q;
	logic [2:0]  cc_q;
	logic        run_q;
	logic [ADDR_BITS:0] clr_q;
	cmd_t        c_q;
	logic        ov_q;
	out_item_t   od_q;

	logic                 we;
	logic [ADDR_BITS-1:0] wa, ra;
	logic [15:0]          wd;
	logic [15:0] pc1, off9, ea9, base6;
	logic [2:0]  dr, sr1, sr2;
	logic [3:0]  opc;

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && (!ov_q || !out_stall);

	assign dr    = ir_q[11:9];
	assign sr1   = ir_q[8:6];
	assign sr2   = ir_q[2:0];
	assign opc   = ir_q[15:12];
	assign pc1   = pc_q + 16'd1;
	assign off9  = sext(ir_q, 9);
	assign ea9   = pc1 + off9;
	assign base6 = rf_q[sr1] + sext(ir_q, 6);

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	// Memory port control.
	always_comb begin
		we = 1'b0;
		wa = cmd.mem_address[ADDR_BITS-1:0];
		wd = cmd.mem_data;
		ra = pc_q[ADDR_BITS-1:0];
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1; wa = clr_q[ADDR_BITS-1:0]; wd = 16'd0;
			end
			S_IDLE: we = cmd_take && (cmd.op == OP_WRITE);
			S_DECODE: begin
				if (rd_q != 16'd0) begin
					unique case (rd_q[15:12])
						4'd3: begin
							we = 1'b1;
							wa = (pc1 + sext(rd_q, 9)) ;
							wd = rf_q[rd_q[11:9]];
						end
						4'd7: begin
							we = 1'b1;
							wa = (rf_q[rd_q[8:6]] + sext(rd_q, 6));
							wd = rf_q[rd_q[11:9]];
						end
						4'd6: ra = (rf_q[rd_q[8:6]] + sext(rd_q, 6));
						default: ra = (pc1 + sext(rd_q, 9));
					endcase
				end
			end
			S_IND: begin
				ra = rd_q[ADDR_BITS-1:0];
				if (opc == 4'd11) begin
					we = 1'b1; wa = rd_q[ADDR_BITS-1:0]; wd = rf_q[dr];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		logic        wv, cv, setcc;
		logic [2:0]  wi;
		logic [15:0] wval, npc;
		logic [1:0]  st;
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			pc_q    <= 16'd0;
			ir_q    <= 16'd0;
			cc_q    <= 3'b010;
			run_q   <= 1'b1;
			ov_q    <= 1'b0;
			for (int i = 0; i < 8; i++) rf_q[i] <= 16'd0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ADDR_BITS+1)'(MEM_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_take) begin
						c_q <= cmd;
						od_q <= '0;
						od_q.cond_codes <= cc_q;
						unique case (cmd.op)
							OP_RESTART: begin
								pc_q <= start_address; run_q <= 1'b1;
								od_q.pc_value <= start_address;
								od_q.is_running <= 1'b1;
								ov_q <= 1'b1;
							end
							OP_EXEC: begin
								if (!run_q) begin
									od_q.pc_value <= pc_q;
									od_q.status <= ST_STOP;
									ov_q <= 1'b1;
								end else state_q <= S_FETCH;
							end
							default: begin
								od_q.pc_value <= pc_q;
								od_q.is_running <= run_q;
								ov_q <= 1'b1;
							end
						endcase
					end
				end
				S_FETCH: state_q <= S_DECODE;
				S_DECODE: begin
					if (rd_q == 16'd0) begin
						run_q <= 1'b0;
						od_q.pc_value <= pc_q;
						od_q.status <= ST_STOP;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ir_q <= rd_q;
						if (rd_q[15:12] == 4'd10 || rd_q[15:12] == 4'd11) state_q <= S_IND;
						else state_q <= S_FINISH;
					end
				end
				S_IND: state_q <= S_FINISH;
				S_FINISH: begin
					wv = 1'b0; cv = 1'b0; setcc = 1'b0; wi = dr;
					wval = 16'd0; npc = pc1; st = ST_OK;
					unique case (opc)
						4'd0: if ((dr & cc_q) != 3'd0) npc = ea9;
						4'd1, 4'd5: begin
							logic [15:0] b;
							b = (ir_q & IMM_BIT) != 16'd0 ? sext(ir_q, 5) : rf_q[sr2];
							wval = (opc == 4'd1) ? rf_q[sr1] + b : rf_q[sr1] & b;
							wv = 1'b1; setcc = 1'b1;
						end
						4'd2, 4'd6, 4'd10: begin
							wval = rd_q; wv = 1'b1; setcc = 1'b1;
						end
						4'd4: begin
							npc = (ir_q & JSR_BIT) != 16'd0 ? pc1 + sext(ir_q, 11)
							                                : rf_q[sr1];
							wval = pc1; wv = 1'b1; wi = 3'd7;
						end
						4'd9: begin
							wval = ~rf_q[sr1]; wv = 1'b1; setcc = 1'b1;
						end
						4'd12: npc = rf_q[sr1];
						4'd14: begin
							wval = ea9; wv = 1'b1; setcc = 1'b1;
						end
						4'd15: begin
							if (ir_q[7:0] == TRAP_GETC) begin
								wval = {8'd0, c_q.char_in}; wv = 1'b1; wi = 3'd0;
							end else if (ir_q[7:0] == TRAP_OUT) cv = 1'b1;
							else if (ir_q[7:0] == TRAP_HALT) st = ST_STOP;
						end
						4'd8, 4'd13: st = ST_RSVD;
						default: ;
					endcase
					pc_q <= npc;
					if (wv) rf_q[wi] <= wval;
					if (setcc) cc_q <= flags_of(wval);
					if (st == ST_STOP) run_q <= 1'b0;
					od_q.pc_value <= npc;
					od_q.instr_word <= ir_q;
					od_q.is_running <= (st != ST_STOP);
					od_q.status <= st;
					od_q.reg_write_valid <= wv;
					od_q.reg_write_index <= wv ? wi : 3'd0;
					od_q.reg_write_value <= wv ? wval : 16'd0;
					od_q.cond_codes <= setcc ? flags_of(wval) : cc_q;
					od_q.char_out_valid <= cv;
					od_q.char_out <= cv ? rf_q[0][7:0] : 8'd0;
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/lc3_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// LC-3 instruction executor
// Top level: APB register, front-end queue and execution back end.
// ----------------------------------------------------------------------------
// After reset the core clears its 65536-word memory, one word a cycle. The
// back end takes no transaction meanwhile, but the queue fills and APB
// writes still work. A memory write or restart is done in the idle state,
// so such transactions can follow back to back while the output is not
// stalled. An execute steps through fetch, decode with any data read or
// store, and finish, plus an indirect step for LDI and STI, whose pointer
// needs a second read through the memory's one read port. A two-entry front
// queue accepts until full while the back end works or its result waits.
// ----------------------------------------------------------------------------
module lc3_instruction_executor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [0:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  lc3_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output lc3_pkg::out_item_t out_data
);
	import lc3_pkg::*;

	logic [15:0] start_q;
	logic        cmd_valid, cmd_take;
	cmd_t        cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {16'd0, start_q} : 32'd0;

	// The start address register sits at byte address zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= 16'd0;
		else if (psel && penable && pwrite && paddr == 1'b0) start_q <= pwdata[15:0];
	end

	lc3_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	lc3_back u_back (
		.clk(clk), .arst_n(arst_n), .start_address(start_q),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule
